// File: sv/sdws_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdws_pkg
// Shared types and constants of the serial DAC write sequencer.
// ----------------------------------------------------------------------------
package sdws_pkg;

  localparam int unsigned WORD_BITS_DEF = 16;
  localparam int unsigned AMP_W         = 16;
  localparam int unsigned RETRY_W       = 8;
  localparam int unsigned POLL_W        = 9;
  localparam logic [RETRY_W-1:0] RETRY_RESET = 8'd100;
  localparam int unsigned QUEUE_DEPTH   = 2;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_POLL      = 4'd1,
    PH_CLEAR     = 4'd2,
    PH_BIT_DATA  = 4'd3,
    PH_BIT_CLOCK = 4'd4,
    PH_CLK_LOW   = 4'd5,
    PH_CS_HIGH   = 4'd6,
    PH_CS_LOW    = 4'd7,
    PH_RELEASE   = 4'd8
  } phase_t;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [AMP_W-1:0] amplitude;
    logic             grant;
  } cmd_t;

endpackage
`default_nettype wire

// File: sv/sdws_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdws_front
// Accepts input items, classifies them into start or tick commands and holds
// them in a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module sdws_front
  import sdws_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_kind,
  input  wire logic [AMP_W-1:0] in_amplitude,
  input  wire logic             in_grant,
  output logic                  q_valid,
  input  wire logic             q_ready,
  output cmd_t                  q_cmd
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q_mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;
  cmd_t             new_cmd;

  always_comb begin
    new_cmd.op        = in_kind ? CMD_START : CMD_TICK;
    new_cmd.amplitude = in_amplitude;
    new_cmd.grant     = in_grant;
  end

  assign in_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_cmd    = q_mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule
`default_nettype wire

// File: sv/sdws_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdws_back
// Pin sequencer: one command per cycle unless the output stalls, through the
// grant poll and serial write steps; holds the result in an output register.
// ----------------------------------------------------------------------------
module sdws_back
  import sdws_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [RETRY_W-1:0] retry_limit,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  wire cmd_t               q_cmd,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_request_line,
  output logic                    out_serial_clock,
  output logic                    out_serial_data,
  output logic                    out_chip_select,
  output logic                    out_busy_res,
  output logic                    out_done_res,
  output logic                    out_not_granted
);

  localparam int unsigned BL_W = $clog2(WORD_BITS + 1);

  phase_t                phase_r, phase_nxt;
  logic [WORD_BITS-1:0]  shift_r, shift_nxt;
  logic [BL_W-1:0]       bits_left_r, bits_left_nxt;
  logic [POLL_W-1:0]     poll_r, poll_nxt;
  logic                  req_r, req_nxt;
  logic                  clk_pin_r, clk_pin_nxt;
  logic                  dat_r, dat_nxt;
  logic                  cs_r, cs_nxt;
  logic                  done, fail, pop;
  logic [31:0]           amp_ext;

  logic out_valid_r, out_valid_nxt;
  logic out_req_r, out_clk_r, out_dat_r, out_cs_r;
  logic out_busy_r, out_done_r, out_fail_r;

  assign q_ready = !out_valid_r || out_ready;
  assign pop     = q_valid && q_ready;
  assign amp_ext = 32'(q_cmd.amplitude);

  always_comb begin
    phase_nxt     = phase_r;
    shift_nxt     = shift_r;
    bits_left_nxt = bits_left_r;
    poll_nxt      = poll_r;
    req_nxt       = req_r;
    clk_pin_nxt   = clk_pin_r;
    dat_nxt       = dat_r;
    cs_nxt        = cs_r;
    done          = 1'b0;
    fail          = 1'b0;
    if (pop) begin
      if (q_cmd.op == CMD_START) begin
        // start while busy is dropped
        if (phase_r == PH_IDLE) begin
          shift_nxt     = amp_ext[WORD_BITS-1:0];
          bits_left_nxt = '0;
          poll_nxt      = '0;
          req_nxt       = 1'b1;
          phase_nxt     = PH_POLL;
        end
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
          end
          PH_POLL: begin
            // limit check wins over a late grant
            if (poll_r > POLL_W'(retry_limit)) begin
              req_nxt   = 1'b0;
              fail      = 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              poll_nxt = poll_r + 1'b1;
              if (q_cmd.grant) begin
                phase_nxt = PH_CLEAR;
              end
            end
          end
          PH_CLEAR: begin
            clk_pin_nxt   = 1'b0;
            dat_nxt       = 1'b0;
            cs_nxt        = 1'b0;
            bits_left_nxt = BL_W'(WORD_BITS);
            phase_nxt     = PH_BIT_DATA;
          end
          PH_BIT_DATA: begin
            clk_pin_nxt = 1'b0;
            dat_nxt     = shift_r[WORD_BITS-1];
            shift_nxt   = shift_r << 1;
            phase_nxt   = PH_BIT_CLOCK;
          end
          PH_BIT_CLOCK: begin
            clk_pin_nxt = 1'b1;
            if (bits_left_r != '0) begin
              bits_left_nxt = bits_left_r - 1'b1;
            end
            phase_nxt = (bits_left_nxt == '0) ? PH_CLK_LOW : PH_BIT_DATA;
          end
          PH_CLK_LOW: begin
            clk_pin_nxt = 1'b0;
            phase_nxt   = PH_CS_HIGH;
          end
          PH_CS_HIGH: begin
            cs_nxt    = 1'b1;
            phase_nxt = PH_CS_LOW;
          end
          PH_CS_LOW: begin
            cs_nxt    = 1'b0;
            dat_nxt   = 1'b0;
            phase_nxt = PH_RELEASE;
          end
          PH_RELEASE: begin
            req_nxt   = 1'b0;
            done      = 1'b1;
            phase_nxt = PH_IDLE;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      shift_r     <= '0;
      bits_left_r <= '0;
      poll_r      <= '0;
      req_r       <= 1'b0;
      clk_pin_r   <= 1'b0;
      dat_r       <= 1'b0;
      cs_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      shift_r     <= shift_nxt;
      bits_left_r <= bits_left_nxt;
      poll_r      <= poll_nxt;
      req_r       <= req_nxt;
      clk_pin_r   <= clk_pin_nxt;
      dat_r       <= dat_nxt;
      cs_r        <= cs_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register, loaded on each command transfer
  always_ff @(posedge clk) begin
    if (pop) begin
      out_req_r  <= req_nxt;
      out_clk_r  <= clk_pin_nxt;
      out_dat_r  <= dat_nxt;
      out_cs_r   <= cs_nxt;
      out_busy_r <= (phase_nxt != PH_IDLE);
      out_done_r <= done;
      out_fail_r <= fail;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_request_line = out_req_r;
  assign out_serial_clock = out_clk_r;
  assign out_serial_data  = out_dat_r;
  assign out_chip_select  = out_cs_r;
  assign out_busy_res     = out_busy_r;
  assign out_done_res     = out_done_r;
  assign out_not_granted  = out_fail_r;

  a_done_fail_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_done_r && out_fail_r))
    else $error("done and not_granted reported together");

  a_end_releases: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_done_r || out_fail_r)) |-> (!out_req_r && !out_busy_r))
    else $error("sequence ended without releasing the request");

  a_busy_holds_req: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> req_r)
    else $error("request low while a sequence is running");

  a_bits_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BIT_DATA || phase_r == PH_BIT_CLOCK) |-> (bits_left_r != '0))
    else $error("bit phase with no bits left");

endmodule
`default_nettype wire

// File: sv/serial_dac_write_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// serial_dac_write_sequencer
// MSB-first serial DAC write with bus request, grant polling and load strobe.
// ----------------------------------------------------------------------------
// Every transfer on the input channel gives exactly one result. A start item
// loads the word and raises the request when the sequencer is idle; each tick
// item advances the pin sequence by one step. Throughput is one item per clock
// cycle unless the output stalls. An item passes through the two-entry command
// queue and then the sequencer step, which writes the result register. The
// command queue lets a new item enter while a result still waits.
// retry_limit may be written only while no item is in flight.
module serial_dac_write_sequencer
  import sdws_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [RETRY_W-1:0] cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_kind,
  input  wire logic [AMP_W-1:0]   in_amplitude,
  input  wire logic               in_grant,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_request_line,
  output logic                    out_serial_clock,
  output logic                    out_serial_data,
  output logic                    out_chip_select,
  output logic                    out_busy_res,
  output logic                    out_done_res,
  output logic                    out_not_granted
);

  logic [RETRY_W-1:0] retry_limit_r;
  logic               q_valid, q_ready;
  cmd_t               q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= RETRY_RESET;
    end else if (cfg_we) begin
      retry_limit_r <= cfg_wdata;
    end
  end

  sdws_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_amplitude (in_amplitude),
    .in_grant     (in_grant),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_cmd        (q_cmd)
  );

  sdws_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .retry_limit      (retry_limit_r),
    .q_valid          (q_valid),
    .q_ready          (q_ready),
    .q_cmd            (q_cmd),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_request_line (out_request_line),
    .out_serial_clock (out_serial_clock),
    .out_serial_data  (out_serial_data),
    .out_chip_select  (out_chip_select),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_not_granted  (out_not_granted)
  );

endmodule
`default_nettype wire
